// ===== rtl/modbus_rtu_request_checker_macros.svh =====
// assertion macros used by the request checker assertions in mbrc_checker.sv
`ifndef MODBUS_RTU_REQUEST_CHECKER_MACROS_SVH
`define MODBUS_RTU_REQUEST_CHECKER_MACROS_SVH

// concurrent assertion, switched off while reset is high
`define MBRC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("request checker assertion failed");

// concurrent assertion, also checked during reset
`define MBRC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("request checker reset assertion failed");

`endif

// ===== rtl/mbrc_pkg.sv =====
// types, codes and the crc step for the modbus rtu request checker
`default_nettype none

package mbrc_pkg;

  // frame size limits
  localparam int unsigned MAX_FRAME  = 256;
  localparam int unsigned COUNT_W    = $clog2(MAX_FRAME + 1);
  localparam int unsigned HEADER_LEN = 6;
  localparam int unsigned HDR_IDX_W  = $clog2(HEADER_LEN);
  localparam int unsigned MIN_FRAME  = 4;

  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [HDR_IDX_W-1:0] hdr_idx_t;
  typedef logic [2:0]           status_t;
  typedef logic [0:0]           cfg_index_t;

  // result status codes
  localparam status_t ST_OK            = 3'd0;
  localparam status_t ST_BAD_FUNC      = 3'd1;
  localparam status_t ST_BAD_CRC       = 3'd2;
  localparam status_t ST_OTHER_STATION = 3'd3;
  localparam status_t ST_TOO_LONG      = 3'd4;
  localparam status_t ST_TOO_SHORT     = 3'd5;

  // input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // supported function codes
  localparam logic [7:0] FC_READ_COILS     = 8'd1;
  localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
  localparam logic [7:0] FC_WRITE_SINGLE   = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTIPLE = 8'd16;

  // configuration register indexes and reset values
  localparam cfg_index_t REG_STATION_ADDRESS = 1'b0;
  localparam cfg_index_t REG_SILENCE_LIMIT   = 1'b1;
  localparam logic [7:0] STATION_RESET       = 8'd1;
  localparam logic [7:0] SILENCE_RESET       = 8'd5;

  // crc-16 modbus, reflected polynomial
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // one byte through the crc, bit at a time
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mbrc_ifs.sv =====
// valid/ready channels for received bytes and frame reports
`default_nettype none

interface mbrc_byte_if;
  import mbrc_pkg::*;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface mbrc_report_if;
  import mbrc_pkg::*;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [7:0]  function_code;
  logic [15:0] start_address;
  logic [15:0] quantity_or_value;
  count_t      frame_length;

  modport source (output valid, status, function_code, start_address, quantity_or_value,
                  frame_length, input ready);
  modport sink   (input valid, status, function_code, start_address, quantity_or_value,
                  frame_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/modbus_rtu_request_checker.sv =====
// modbus rtu request checker: frame assembly, silence timeout, crc and header checks
//
//   channel  | dir  | payload                                             | one transaction
//   bytes    | sink | command, rx_byte                                    | a byte or a 1 ms tick
//   report   | src  | status, function_code, start_address,               | one closed frame
//            |      | quantity_or_value, frame_length                     |
//   cfg      | sink | cfg_wr_en, cfg_index, cfg_data                      | one register write
//
// one transaction per cycle unless a held report stalls it; the crc byte step and the
// frame checks sit between the input register and the report register, so a report
// is registered once the closing tick in the input register is taken.
// rst is synchronous: frame state clears, station_address = 1, silence_limit = 5.
// report.ready low holds the report; one more transaction waits in the input
// register, after which bytes.ready drops.
`default_nettype none

module modbus_rtu_request_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  mbrc_pkg::cfg_index_t cfg_index,
  input  logic [7:0]          cfg_data,
  mbrc_byte_if.sink           bytes,
  mbrc_report_if.source       report
);
  import mbrc_pkg::*;

  // configuration registers
  logic [7:0] station_address;
  logic [7:0] silence_limit;

  // input register
  logic       s1_valid;
  logic       s1_command;
  logic [7:0] s1_rx_byte;

  // frame state
  count_t      byte_count, byte_count_next;
  logic [7:0]  silence_count, silence_count_next;
  logic [7:0]  header_bytes [HEADER_LEN];
  logic [7:0]  tail_bytes [2];
  logic [7:0]  tail0_next, tail1_next;
  logic [15:0] crc_running, crc_running_next;
  logic        overflowed, overflowed_next;

  // report register
  logic        rpt_valid;
  status_t     rpt_status;
  logic [7:0]  rpt_function_code;
  logic [15:0] rpt_start_address;
  logic [15:0] rpt_quantity;
  count_t      rpt_frame_length;

  logic       advance;
  logic       take;
  logic       hdr_we;
  hdr_idx_t   hdr_idx;
  logic       close;
  logic [8:0] silence_plus;
  status_t    status_now;
  logic [7:0] fc_now;
  logic [15:0] start_now;
  logic [15:0] quantity_now;

  assign advance     = !rpt_valid || report.ready;
  assign bytes.ready = !s1_valid || advance;
  assign take        = s1_valid && advance;
  assign hdr_idx     = byte_count[HDR_IDX_W-1:0];
  assign silence_plus = {1'b0, silence_count} + 9'd1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= STATION_RESET;
      silence_limit   <= SILENCE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_STATION_ADDRESS: station_address <= cfg_data;
        REG_SILENCE_LIMIT:   silence_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_command <= bytes.command;
      s1_rx_byte <= bytes.rx_byte;
    end
  end

  // frame checks on the held state, in priority order
  always_comb begin
    priority if (overflowed) begin
      status_now = ST_TOO_LONG;
    end else if (byte_count < count_t'(MIN_FRAME)) begin
      status_now = ST_TOO_SHORT;
    end else if (header_bytes[0] != station_address) begin
      status_now = ST_OTHER_STATION;
    end else if (tail_bytes[0] != crc_running[7:0] || tail_bytes[1] != crc_running[15:8]) begin
      status_now = ST_BAD_CRC;
    end else if (header_bytes[1] == FC_READ_HOLDING || header_bytes[1] == FC_WRITE_MULTIPLE ||
                 header_bytes[1] == FC_READ_COILS   || header_bytes[1] == FC_WRITE_SINGLE) begin
      status_now = ST_OK;
    end else begin
      status_now = ST_BAD_FUNC;
    end
  end

  // reported fields, zero where the frame does not reach them
  assign fc_now       = (byte_count >= count_t'(2)) ? header_bytes[1] : 8'h00;
  assign start_now    = (byte_count >= count_t'(4)) ? {header_bytes[2], header_bytes[3]} : 16'h0000;
  assign quantity_now = (byte_count >= count_t'(6)) ? {header_bytes[4], header_bytes[5]} : 16'h0000;

  // next frame state for the transaction in the input register
  always_comb begin
    byte_count_next    = byte_count;
    silence_count_next = silence_count;
    tail0_next         = tail_bytes[0];
    tail1_next         = tail_bytes[1];
    crc_running_next   = crc_running;
    overflowed_next    = overflowed;
    hdr_we             = 1'b0;
    close              = 1'b0;
    if (take) begin
      if (s1_command == CMD_BYTE) begin
        silence_count_next = 8'h00;
        if (byte_count >= count_t'(MAX_FRAME)) begin
          overflowed_next = 1'b1;
        end else begin
          hdr_we = (byte_count < count_t'(HEADER_LEN));
          if (byte_count >= count_t'(2)) begin
            crc_running_next = crc_feed(crc_running, tail_bytes[0]);
          end
          tail0_next      = tail_bytes[1];
          tail1_next      = s1_rx_byte;
          byte_count_next = byte_count + count_t'(1);
        end
      end else if (byte_count != '0) begin
        if (silence_plus <= {1'b0, silence_limit}) begin
          silence_count_next = silence_plus[7:0];
        end else begin
          close              = 1'b1;
          byte_count_next    = '0;
          silence_count_next = 8'h00;
          tail0_next         = 8'h00;
          tail1_next         = 8'h00;
          crc_running_next   = CRC_INIT;
          overflowed_next    = 1'b0;
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      silence_count <= 8'h00;
      tail_bytes[0] <= 8'h00;
      tail_bytes[1] <= 8'h00;
      crc_running   <= CRC_INIT;
      overflowed    <= 1'b0;
    end else begin
      byte_count    <= byte_count_next;
      silence_count <= silence_count_next;
      tail_bytes[0] <= tail0_next;
      tail_bytes[1] <= tail1_next;
      crc_running   <= crc_running_next;
      overflowed    <= overflowed_next;
    end
  end

  // first header bytes, written in arrival order
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      header_bytes[hdr_idx] <= s1_rx_byte;
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (close) begin
      rpt_valid <= 1'b1;
    end else if (report.ready) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (close) begin
      rpt_status        <= status_now;
      rpt_function_code <= fc_now;
      rpt_start_address <= start_now;
      rpt_quantity      <= quantity_now;
      rpt_frame_length  <= byte_count;
    end
  end

  assign report.valid             = rpt_valid;
  assign report.status            = rpt_status;
  assign report.function_code     = rpt_function_code;
  assign report.start_address     = rpt_start_address;
  assign report.quantity_or_value = rpt_quantity;
  assign report.frame_length      = rpt_frame_length;

endmodule

`default_nettype wire

// ===== rtl/mbrc_checker.sv =====
// port-level assertions for the request checker, bound to the top level
`default_nettype none

`include "modbus_rtu_request_checker_macros.svh"

module mbrc_checker (
  input logic               clk,
  input logic               rst,
  input logic               report_valid,
  input mbrc_pkg::status_t  report_status,
  input logic [7:0]         report_function_code,
  input mbrc_pkg::count_t   report_frame_length
);
  import mbrc_pkg::*;

  // no report right after reset
  `MBRC_ASSERT_ALWAYS(a_reset_clears_report, clk, rst |=> !report_valid)

  // a closed frame always held at least one byte and never more than the limit
  `MBRC_ASSERT(a_length_range, clk, rst, report_valid |-> report_frame_length != '0 && report_frame_length <= count_t'(MAX_FRAME))

  // status codes beyond too short are never produced
  `MBRC_ASSERT(a_status_range, clk, rst, report_valid |-> report_status <= ST_TOO_SHORT)

  // too short matches the reported length
  `MBRC_ASSERT(a_short_length, clk, rst, report_valid && report_status == ST_TOO_SHORT |-> report_frame_length < count_t'(MIN_FRAME))

  // an accepted frame carries a known function code
  `MBRC_ASSERT(a_ok_function, clk, rst, report_valid && report_status == ST_OK |-> report_function_code == FC_READ_HOLDING || report_function_code == FC_WRITE_MULTIPLE || report_function_code == FC_READ_COILS || report_function_code == FC_WRITE_SINGLE)

endmodule

bind modbus_rtu_request_checker mbrc_checker u_mbrc_checker (
  .clk                  (clk),
  .rst                  (rst),
  .report_valid         (report.valid),
  .report_status        (report.status),
  .report_function_code (report.function_code),
  .report_frame_length  (report.frame_length)
);

`default_nettype wire
